>>> hdl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare functions of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 9;
    localparam int COORD_W   = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WIN_N     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int LS_W      = 2 * PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] pix;
        logic [COORD_W-1:0]          centre_col;
        logic [COORD_W-1:0]          centre_row;
        logic                        frame_end;
    } t_win_item;

    typedef struct packed {
        logic [PIX_W-1:0]   median;
        logic [COORD_W-1:0] centre_col;
        logic [COORD_W-1:0] centre_row;
        logic               frame_end;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (v < DIM_MIN) begin
            res = DIM_MIN;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic t_pix pmin(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix pmax(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return pmax(pmin(a, b), pmin(pmax(a, b), c));
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return pmin(pmin(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return pmax(pmax(a, b), c);
    endfunction

endpackage

>>> hdl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front
// Pixel intake: config registers, raster counters, line stores and window.
// Emits one window item per interior position into the window queue.
// ----------------------------------------------------------------------------
module mf3_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mf3_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_push,
    input  logic [mf3_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_full,
    input  mf3_pkg::t_q_status            i_q_status,
    output logic                          o_q_push,
    output mf3_pkg::t_win_item            o_q_item
);

    logic [mf3_pkg::DIM_W-1:0] r_line_width;
    logic [mf3_pkg::DIM_W-1:0] r_frame_height;
    logic [mf3_pkg::DIM_W-1:0] w_eff;
    logic [mf3_pkg::DIM_W-1:0] h_eff;

    logic [mf3_pkg::COL_W-1:0] r_col;
    logic [mf3_pkg::COL_W-1:0] n_col;
    logic [mf3_pkg::ROW_W-1:0] r_row;
    logic [mf3_pkg::ROW_W-1:0] n_row;

    logic accept;
    logic last_col;
    logic last_row;
    logic emit;

    logic                        r_a_valid;
    logic                        r_a_emit;
    logic [mf3_pkg::PIX_W-1:0]   r_a_px;
    logic [mf3_pkg::COL_W-1:0]   r_a_col;
    logic [mf3_pkg::COORD_W-1:0] r_a_ccol;
    logic [mf3_pkg::COORD_W-1:0] r_a_crow;
    logic                        r_a_fend;

    logic [mf3_pkg::LS_W-1:0]  ls_rdata;
    logic [mf3_pkg::PIX_W-1:0] ls_top;
    logic [mf3_pkg::PIX_W-1:0] ls_mid;

    logic [mf3_pkg::WIN_N-1:0][mf3_pkg::PIX_W-1:0] r_win;
    logic [mf3_pkg::WIN_N-1:0][mf3_pkg::PIX_W-1:0] n_win;

    logic [mf3_pkg::Q_CNT_W:0] q_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH);
            r_frame_height <= mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mf3_pkg::REG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                mf3_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = mf3_pkg::clamp_dim(r_line_width, mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH));
    assign h_eff = mf3_pkg::clamp_dim(r_frame_height, mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT));

    assign q_load = {1'b0, i_q_status.count} + (mf3_pkg::Q_CNT_W + 1)'(r_a_valid & r_a_emit);
    assign o_full = q_load >= (mf3_pkg::Q_CNT_W + 1)'(mf3_pkg::Q_DEPTH);
    assign accept = i_push & ~o_full;

    assign last_col = (mf3_pkg::DIM_W'(r_col) + mf3_pkg::DIM_W'(1)) >= w_eff;
    assign last_row = (mf3_pkg::DIM_W'(r_row) + mf3_pkg::DIM_W'(1)) >= h_eff;
    assign emit     = (r_col >= mf3_pkg::COL_W'(2)) && (r_row >= mf3_pkg::ROW_W'(2));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + mf3_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + mf3_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_emit <= emit;
            r_a_px   <= i_pixel;
            r_a_col  <= r_col;
            r_a_ccol <= mf3_pkg::COORD_W'(r_col - mf3_pkg::COL_W'(1));
            r_a_crow <= mf3_pkg::COORD_W'(r_row - mf3_pkg::ROW_W'(1));
            r_a_fend <= last_col & last_row;
        end
    end

    mf3_ram #(
        .WIDTH (mf3_pkg::LS_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata ({ls_mid, r_a_px}),
        .i_raddr (r_col),
        .o_rdata (ls_rdata)
    );

    assign ls_top = ls_rdata[mf3_pkg::LS_W-1:mf3_pkg::PIX_W];
    assign ls_mid = ls_rdata[mf3_pkg::PIX_W-1:0];

    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[k*3 + 0] = r_win[k*3 + 1];
            n_win[k*3 + 1] = r_win[k*3 + 2];
        end
        n_win[2] = ls_top;
        n_win[5] = ls_mid;
        n_win[8] = r_a_px;
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_win <= n_win;
        end
    end

    assign o_q_push            = r_a_valid & r_a_emit;
    assign o_q_item.pix        = n_win;
    assign o_q_item.centre_col = r_a_ccol;
    assign o_q_item.centre_row = r_a_crow;
    assign o_q_item.frame_end  = r_a_fend;

endmodule

>>> hdl/mf3_queue.sv
// ----------------------------------------------------------------------------
// mf3_queue
// Short queue of window items between intake and the median pipeline.
// ----------------------------------------------------------------------------
module mf3_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mf3_pkg::t_win_item i_item,
    input  logic               i_pop,
    output mf3_pkg::t_win_item o_item,
    output mf3_pkg::t_q_status o_status
);

    mf3_pkg::t_win_item r_mem [mf3_pkg::Q_DEPTH];

    logic [mf3_pkg::Q_PTR_W-1:0] r_wr;
    logic [mf3_pkg::Q_PTR_W-1:0] r_rd;
    logic [mf3_pkg::Q_CNT_W-1:0] r_cnt;
    logic                        do_pop;

    assign do_pop = i_pop & (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + mf3_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + mf3_pkg::Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + mf3_pkg::Q_CNT_W'(i_push) - mf3_pkg::Q_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd];
    assign o_status.valid = r_cnt != '0;
    assign o_status.count = r_cnt;

endmodule

>>> hdl/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back
// Median pipeline: row sort, max-of-min / median-of-median / min-of-max,
// final median of three, then the result queue.
// ----------------------------------------------------------------------------
module mf3_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mf3_pkg::t_q_status i_q_status,
    input  mf3_pkg::t_win_item i_q_item,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output mf3_pkg::t_out_item o_item
);

    logic [2:0][mf3_pkg::PIX_W-1:0] row_lo;
    logic [2:0][mf3_pkg::PIX_W-1:0] row_md;
    logic [2:0][mf3_pkg::PIX_W-1:0] row_hi;

    logic                           r_s1_valid;
    logic [2:0][mf3_pkg::PIX_W-1:0] r_s1_lo;
    logic [2:0][mf3_pkg::PIX_W-1:0] r_s1_md;
    logic [2:0][mf3_pkg::PIX_W-1:0] r_s1_hi;
    logic [mf3_pkg::COORD_W-1:0]    r_s1_ccol;
    logic [mf3_pkg::COORD_W-1:0]    r_s1_crow;
    logic                           r_s1_fend;

    logic                        r_s2_valid;
    logic [mf3_pkg::PIX_W-1:0]   r_s2_lo;
    logic [mf3_pkg::PIX_W-1:0]   r_s2_md;
    logic [mf3_pkg::PIX_W-1:0]   r_s2_hi;
    logic [mf3_pkg::COORD_W-1:0] r_s2_ccol;
    logic [mf3_pkg::COORD_W-1:0] r_s2_crow;
    logic                        r_s2_fend;

    mf3_pkg::t_out_item r_fifo [mf3_pkg::OUT_DEPTH];
    mf3_pkg::t_out_item res;

    logic [mf3_pkg::OUT_PTR_W-1:0] r_wr;
    logic [mf3_pkg::OUT_PTR_W-1:0] r_rd;
    logic [mf3_pkg::OUT_CNT_W-1:0] r_cnt;
    logic [mf3_pkg::OUT_CNT_W:0]   load;
    logic                          do_pop;

    assign load = {1'b0, r_cnt} + (mf3_pkg::OUT_CNT_W + 1)'(r_s1_valid)
                + (mf3_pkg::OUT_CNT_W + 1)'(r_s2_valid);
    assign o_q_pop = i_q_status.valid
                   & (load < (mf3_pkg::OUT_CNT_W + 1)'(mf3_pkg::OUT_DEPTH));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            row_lo[i] = mf3_pkg::min3(i_q_item.pix[i*3], i_q_item.pix[i*3 + 1],
                                      i_q_item.pix[i*3 + 2]);
            row_md[i] = mf3_pkg::med3(i_q_item.pix[i*3], i_q_item.pix[i*3 + 1],
                                      i_q_item.pix[i*3 + 2]);
            row_hi[i] = mf3_pkg::max3(i_q_item.pix[i*3], i_q_item.pix[i*3 + 1],
                                      i_q_item.pix[i*3 + 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_q_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_lo   <= row_lo;
            r_s1_md   <= row_md;
            r_s1_hi   <= row_hi;
            r_s1_ccol <= i_q_item.centre_col;
            r_s1_crow <= i_q_item.centre_row;
            r_s1_fend <= i_q_item.frame_end;
        end
        if (r_s1_valid) begin
            r_s2_lo   <= mf3_pkg::max3(r_s1_lo[0], r_s1_lo[1], r_s1_lo[2]);
            r_s2_md   <= mf3_pkg::med3(r_s1_md[0], r_s1_md[1], r_s1_md[2]);
            r_s2_hi   <= mf3_pkg::min3(r_s1_hi[0], r_s1_hi[1], r_s1_hi[2]);
            r_s2_ccol <= r_s1_ccol;
            r_s2_crow <= r_s1_crow;
            r_s2_fend <= r_s1_fend;
        end
    end

    assign res.median     = mf3_pkg::med3(r_s2_lo, r_s2_md, r_s2_hi);
    assign res.centre_col = r_s2_ccol;
    assign res.centre_row = r_s2_crow;
    assign res.frame_end  = r_s2_fend;

    assign do_pop = i_pop & (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wr <= r_wr + mf3_pkg::OUT_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + mf3_pkg::OUT_PTR_W'(1);
            end
            r_cnt <= r_cnt + mf3_pkg::OUT_CNT_W'(r_s2_valid) - mf3_pkg::OUT_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_fifo[r_wr] <= res;
        end
    end

    assign o_empty = r_cnt == '0;
    assign o_item  = r_fifo[r_rd];

endmodule

>>> hdl/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter over raster-order 8-bit pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while full is low and gives,
// for every position whose 3x3 neighborhood lies inside the frame, the
// median of the nine pixels with the centre coordinates and a mark on the
// last median of the frame; border positions give nothing. Sustained rate
// is one pixel per clock while results are popped. A result reaches the
// output queue through the line-store read and window update, the window
// queue and the two-stage median network. Line width and frame height are
// clamped to 3..256; the user must write them while idle (not enforced).
// ----------------------------------------------------------------------------
module median_filter_3x3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mf3_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [mf3_pkg::PIX_W-1:0]     i_pixel,
    output logic                          empty,
    input  logic                          pop,
    output logic [mf3_pkg::PIX_W-1:0]     o_median,
    output logic [mf3_pkg::COORD_W-1:0]   o_centre_col,
    output logic [mf3_pkg::COORD_W-1:0]   o_centre_row,
    output logic                          o_frame_end
);

    mf3_pkg::t_q_status q_status;
    mf3_pkg::t_win_item q_in;
    mf3_pkg::t_win_item q_out;
    mf3_pkg::t_out_item res;
    logic               q_push;
    logic               q_pop;

    mf3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_pixel    (i_pixel),
        .o_full     (full),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_q_item   (q_in)
    );

    mf3_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (q_in),
        .i_pop    (q_pop),
        .o_item   (q_out),
        .o_status (q_status)
    );

    mf3_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_item   (q_out),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_item     (res)
    );

    assign o_median     = res.median;
    assign o_centre_col = res.centre_col;
    assign o_centre_row = res.centre_row;
    assign o_frame_end  = res.frame_end;

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= mf3_pkg::Q_CNT_W'(mf3_pkg::Q_DEPTH))
        else $error("window queue overfilled");

    a_q_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.count == mf3_pkg::Q_CNT_W'(mf3_pkg::Q_DEPTH)) |-> full)
        else $error("intake open while window queue is full");

    a_q_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_status.count != mf3_pkg::Q_CNT_W'(mf3_pkg::Q_DEPTH)) || q_pop)
        else $error("window item pushed into a full queue");

    a_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_centre_col != '0) && (o_centre_row != '0))
        else $error("result centre on the frame border");

endmodule
